// ----- hdl/spw_pkg.sv -----
// Shared types, codes and constants for the serial pinged watchdog.
// No dependencies; imported by the interfaces' users, spw_ctrl and spw_dp.
package spw_pkg;

  localparam logic [1:0] CMD_SEC  = 2'd0;
  localparam logic [1:0] CMD_BYTE = 2'd1;
  localparam logic [1:0] CMD_MS   = 2'd2;

  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_PING  = 3'd1;
  localparam logic [2:0] EV_SHOW  = 3'd2;
  localparam logic [2:0] EV_SET   = 3'd3;
  localparam logic [2:0] EV_WRONG = 3'd4;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  localparam logic [1:0] CFG_BOOT   = 2'd0;
  localparam logic [1:0] CFG_PHASE  = 2'd1;
  localparam logic [1:0] CFG_TONE1  = 2'd2;
  localparam logic [1:0] CFG_TONE2  = 2'd3;

  localparam logic [15:0] BOOT_RST  = 16'd10;
  localparam logic [15:0] PHASE_RST = 16'd500;
  localparam logic [7:0]  TONE1_RST = 8'd104;
  localparam logic [7:0]  TONE2_RST = 8'd83;
  localparam int unsigned COUNT_RST = 10;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] WORD_PING = 32'h70696E67;
  localparam logic [31:0] WORD_SHOW = 32'h73686F77;
  localparam logic [31:0] WORD_SET  = 32'h73657400;
  localparam int unsigned WORD_SET_LEN = 3;
  localparam int unsigned MATCH_SPAN   = 4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_STRIP_RD,
    OP_STRIP_CHK,
    OP_MATCH_RD,
    OP_MATCH_CHK,
    OP_MATCH_END,
    OP_PARSE_RD,
    OP_PARSE_CHK,
    OP_PARSE_END,
    OP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic run_line;
    logic n_zero;
    logic strip_hit;
    logic match_last;
    logic go_parse;
    logic parse_end;
    logic parse_stop;
  } dp_sts_t;

  // character i of a four-character word, zero past its end
  function automatic logic [7:0] word_char(input logic [31:0] w, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (i)
      3'd0:    c = w[31:24];
      3'd1:    c = w[23:16];
      3'd2:    c = w[15:8];
      3'd3:    c = w[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/spw_in_if.sv -----
// Input channel: valid/ready handshake carrying one command item.
// No dependencies.
interface spw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// ----- hdl/spw_out_if.sv -----
// Output channel: valid/ready handshake carrying one status result.
// No dependencies.
interface spw_out_if;
  logic        valid;
  logic        ready;
  logic        pulse_led;
  logic        alert_led;
  logic        relay_on;
  logic        buzzer_on;
  logic [7:0]  tone_divider;
  logic        echo_valid;
  logic [7:0]  echo_byte;
  logic [2:0]  event_res;
  logic [15:0] reported_limit;
  logic [15:0] seconds_remaining;

  modport source (output valid, output pulse_led, output alert_led, output relay_on,
                  output buzzer_on, output tone_divider, output echo_valid, output echo_byte,
                  output event_res, output reported_limit, output seconds_remaining,
                  input ready);
  modport sink   (input valid, input pulse_led, input alert_led, input relay_on,
                  input buzzer_on, input tone_divider, input echo_valid, input echo_byte,
                  input event_res, input reported_limit, input seconds_remaining,
                  output ready);
endinterface

// ----- hdl/spw_ctrl.sv -----
// Sequencer: handshakes, line scan steps and result loading.
// Depends on spw_pkg; drives spw_dp through ctrl_cmd_t, reads dp_sts_t.
module spw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spw_pkg::ctrl_cmd_t cmd_o,
  input  spw_pkg::dp_sts_t   sts_i
);
  import spw_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_STRIP_RD  = 10'b00_0000_0010,
    ST_STRIP_CHK = 10'b00_0000_0100,
    ST_MATCH_RD  = 10'b00_0000_1000,
    ST_MATCH_CHK = 10'b00_0001_0000,
    ST_MATCH_END = 10'b00_0010_0000,
    ST_PARSE_RD  = 10'b00_0100_0000,
    ST_PARSE_CHK = 10'b00_1000_0000,
    ST_PARSE_END = 10'b01_0000_0000,
    ST_RESULT    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = sts_i.run_line ? ST_STRIP_RD : ST_RESULT;
        end
      end
      ST_STRIP_RD: begin
        if (sts_i.n_zero) begin
          state_d = ST_RESULT;
        end else begin
          cmd_o.op = OP_STRIP_RD;
          state_d  = ST_STRIP_CHK;
        end
      end
      ST_STRIP_CHK: begin
        cmd_o.op = OP_STRIP_CHK;
        state_d  = sts_i.strip_hit ? ST_STRIP_RD : ST_MATCH_RD;
      end
      ST_MATCH_RD: begin
        cmd_o.op = OP_MATCH_RD;
        state_d  = ST_MATCH_CHK;
      end
      ST_MATCH_CHK: begin
        cmd_o.op = OP_MATCH_CHK;
        state_d  = sts_i.match_last ? ST_MATCH_END : ST_MATCH_RD;
      end
      ST_MATCH_END: begin
        cmd_o.op = OP_MATCH_END;
        state_d  = sts_i.go_parse ? ST_PARSE_RD : ST_RESULT;
      end
      ST_PARSE_RD: begin
        if (sts_i.parse_end) begin
          state_d = ST_PARSE_END;
        end else begin
          cmd_o.op = OP_PARSE_RD;
          state_d  = ST_PARSE_CHK;
        end
      end
      ST_PARSE_CHK: begin
        cmd_o.op = OP_PARSE_CHK;
        state_d  = sts_i.parse_stop ? ST_PARSE_END : ST_PARSE_RD;
      end
      ST_PARSE_END: begin
        cmd_o.op = OP_PARSE_END;
        state_d  = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_LOAD_OUT |-> (!out_valid_q || out_ready_i))
    else $error("result register busy at load");
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_LOAD_OUT |=> out_valid_q) else $error("loaded result not presented");
  a_short_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !sts_i.run_line |=> state_q == ST_RESULT) else $error("short item not finished");

endmodule

// ----- hdl/spw_dp.sv -----
// Datapath: watchdog counters, alarm sequencing, line memory, command match and parse.
// Depends on spw_pkg; steered by spw_ctrl through ctrl_cmd_t.
module spw_dp #(
  parameter int unsigned LINE_DEPTH  = 64,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spw_pkg::ctrl_cmd_t cmd_i,
  output spw_pkg::dp_sts_t   sts_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [1:0]         in_cmd_i,
  input  logic [7:0]         in_rx_byte_i,
  output logic               out_pulse_led_o,
  output logic               out_alert_led_o,
  output logic               out_relay_on_o,
  output logic               out_buzzer_on_o,
  output logic [7:0]         out_tone_divider_o,
  output logic               out_echo_valid_o,
  output logic [7:0]         out_echo_byte_o,
  output logic [2:0]         out_event_res_o,
  output logic [15:0]        out_reported_limit_o,
  output logic [15:0]        out_seconds_remaining_o
);
  import spw_pkg::*;

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned LW = $clog2(LINE_DEPTH + 1);
  localparam int unsigned VW = COUNT_WIDTH + 4;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [15:0] boot_q, phms_q;
  logic [7:0]  tone1_q, tone2_q;
  logic [COUNT_WIDTH-1:0] cd_q, limit_q, v_q;
  logic        hb_q;
  logic [1:0]  phase_q;
  logic [15:0] ptimer_q;
  logic [LW-1:0] len_q, n_q, idx_q;
  logic [7:0]  mem [LINE_DEPTH];
  logic [7:0]  rdata_q;
  logic        ping_q, show_q, set_q, neg_q, digits_q;
  logic        echo_v_q;
  logic [7:0]  echo_b_q;
  logic [2:0]  ev_q;

  logic        idle, is_byte, len_room;
  logic [LW-1:0] len_d, n_dec;
  logic [AW-1:0] rd_addr;
  logic [COUNT_WIDTH-1:0] cd_dec, limit_d, v_d;
  logic [VW-1:0] acc;
  logic        is_ws, is_sign, is_dig;
  logic [7:0]  dig_off;

  assign idle     = (phase_q == PH_IDLE);
  assign is_byte  = (in_cmd_i == CMD_BYTE) && idle;
  assign len_room = (len_q < LW'(LINE_DEPTH));
  assign len_d    = len_room ? len_q + LW'(1) : len_q;
  assign n_dec    = n_q - LW'(1);
  assign cd_dec   = cd_q - COUNT_WIDTH'(1);
  assign rd_addr  = (cmd_i.op == OP_STRIP_RD) ? n_dec[AW-1:0] : idx_q[AW-1:0];

  assign is_ws   = (rdata_q == CH_SPACE) || ((rdata_q >= CH_TAB) && (rdata_q <= CH_CR));
  assign is_sign = (rdata_q == CH_PLUS) || (rdata_q == CH_MINUS);
  assign is_dig  = (rdata_q >= CH_ZERO) && (rdata_q <= CH_NINE);
  assign dig_off = rdata_q - CH_ZERO;
  assign acc     = VW'(v_q) * VW'(10) + VW'(dig_off[3:0]);
  assign v_d     = (acc > VW'(CNT_MAX)) ? CNT_MAX : acc[COUNT_WIDTH-1:0];
  assign limit_d = (neg_q || (v_q == '0)) ? COUNT_WIDTH'(1) : v_q;

  assign sts_o.run_line   = is_byte && (in_rx_byte_i == CH_CR);
  assign sts_o.n_zero     = (n_q == '0);
  assign sts_o.strip_hit  = (rdata_q == CH_CR) || (rdata_q == CH_LF);
  assign sts_o.match_last = (idx_q + LW'(1) == n_q) || (idx_q == LW'(MATCH_SPAN));
  assign sts_o.go_parse   = !ping_q && !show_q && set_q && (n_q >= LW'(WORD_SET_LEN));
  assign sts_o.parse_end  = (idx_q >= n_q);
  assign sts_o.parse_stop = digits_q ? !is_dig : !(is_ws || is_sign || is_dig);

  // line memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ACCEPT && is_byte && len_room) begin
      mem[len_q[AW-1:0]] <= in_rx_byte_i;
    end
    rdata_q <= mem[rd_addr];
  end

  // watchdog state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_q   <= BOOT_RST;
      phms_q   <= PHASE_RST;
      tone1_q  <= TONE1_RST;
      tone2_q  <= TONE2_RST;
      cd_q     <= COUNT_WIDTH'(COUNT_RST);
      limit_q  <= COUNT_WIDTH'(COUNT_RST);
      hb_q     <= 1'b0;
      phase_q  <= PH_IDLE;
      ptimer_q <= '0;
      len_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BOOT:  boot_q  <= cfg_data_i;
          CFG_PHASE: phms_q  <= cfg_data_i;
          CFG_TONE1: tone1_q <= cfg_data_i[7:0];
          CFG_TONE2: tone2_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_ACCEPT: begin
          case (in_cmd_i)
            CMD_SEC: begin
              if (idle) begin
                hb_q <= ~hb_q;
                cd_q <= cd_dec;
                if (cd_dec == '0) begin
                  phase_q  <= PH_FIRST;
                  ptimer_q <= phms_q;
                end
              end
            end
            CMD_BYTE: begin
              if (idle) begin
                len_q <= (in_rx_byte_i == CH_CR) ? '0 : len_d;
              end
            end
            CMD_MS: begin
              if (!idle) begin
                if (ptimer_q <= 16'd1) begin
                  if (phase_q == PH_FIRST) begin
                    phase_q  <= PH_SECOND;
                    ptimer_q <= phms_q;
                  end else begin
                    phase_q  <= PH_IDLE;
                    ptimer_q <= '0;
                    cd_q     <= COUNT_WIDTH'(boot_q);
                  end
                end else begin
                  ptimer_q <= ptimer_q - 16'd1;
                end
              end
            end
            default: ;
          endcase
        end
        OP_MATCH_END: begin
          if (ping_q) cd_q <= limit_q;
        end
        OP_PARSE_END: limit_q <= limit_d;
        default: ;
      endcase
    end
  end

  // scan, parse and result registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        echo_v_q <= is_byte;
        echo_b_q <= is_byte ? in_rx_byte_i : 8'h00;
        ev_q     <= EV_NONE;
        n_q      <= len_d;
      end
      OP_STRIP_CHK: begin
        if (sts_o.strip_hit) begin
          n_q <= n_dec;
        end else begin
          idx_q  <= '0;
          ping_q <= 1'b1;
          show_q <= 1'b1;
          set_q  <= 1'b1;
        end
      end
      OP_MATCH_CHK: begin
        if (rdata_q != word_char(WORD_PING, idx_q[2:0])) ping_q <= 1'b0;
        if (rdata_q != word_char(WORD_SHOW, idx_q[2:0])) show_q <= 1'b0;
        if (idx_q < LW'(WORD_SET_LEN) && rdata_q != word_char(WORD_SET, idx_q[2:0])) begin
          set_q <= 1'b0;
        end
        idx_q <= idx_q + LW'(1);
      end
      OP_MATCH_END: begin
        if (ping_q) begin
          ev_q <= EV_PING;
        end else if (show_q) begin
          ev_q <= EV_SHOW;
        end else if (sts_o.go_parse) begin
          ev_q     <= EV_SET;
          idx_q    <= LW'(WORD_SET_LEN);
          v_q      <= '0;
          neg_q    <= 1'b0;
          digits_q <= 1'b0;
        end else begin
          ev_q <= EV_WRONG;
        end
      end
      OP_PARSE_CHK: begin
        if (!sts_o.parse_stop) begin
          idx_q <= idx_q + LW'(1);
          if (is_dig) begin
            v_q      <= v_d;
            digits_q <= 1'b1;
          end else if (!digits_q && is_sign) begin
            neg_q    <= (rdata_q == CH_MINUS);
            digits_q <= 1'b1;
          end
        end
      end
      OP_LOAD_OUT: begin
        out_pulse_led_o         <= hb_q;
        out_alert_led_o         <= !idle;
        out_relay_on_o          <= !idle;
        out_buzzer_on_o         <= !idle;
        out_tone_divider_o      <= (phase_q == PH_FIRST)  ? tone1_q :
                                   (phase_q == PH_SECOND) ? tone2_q : 8'h00;
        out_echo_valid_o        <= echo_v_q;
        out_echo_byte_o         <= echo_b_q;
        out_event_res_o         <= ev_q;
        out_reported_limit_o    <= 16'(limit_q);
        out_seconds_remaining_o <= 16'(cd_q);
      end
      default: ;
    endcase
  end

  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3) else $error("alarm phase out of range");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(LINE_DEPTH)) else $error("line length beyond depth");
  a_timer_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle |-> ptimer_q == '0) else $error("phase timer running while idle");

endmodule

// ----- hdl/serial_pinged_watchdog.sv -----
// A tick or a non-CR byte goes from ST_IDLE to ST_RESULT and is loaded into the output registers
// once the result register is free. A CR byte runs the line: each stripped, compared (up to 5)
// or parsed byte takes a read step and a check step on the single memory read port.
// One item at a time; the next transfer is taken while the last result still waits.
// Reset (async, active low) restores registers, countdown and limit to defaults.
// Depends on spw_pkg, spw_in_if, spw_out_if, spw_ctrl, spw_dp.
module serial_pinged_watchdog #(
  parameter int unsigned LINE_DEPTH  = 64,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spw_in_if.sink      in_i,
  spw_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import spw_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  spw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  spw_dp #(
    .LINE_DEPTH  (LINE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cmd_i                   (cmd),
    .sts_o                   (sts),
    .cfg_we_i                (cfg_we_i),
    .cfg_idx_i               (cfg_idx_i),
    .cfg_data_i              (cfg_data_i),
    .in_cmd_i                (in_i.cmd),
    .in_rx_byte_i            (in_i.rx_byte),
    .out_pulse_led_o         (out_o.pulse_led),
    .out_alert_led_o         (out_o.alert_led),
    .out_relay_on_o          (out_o.relay_on),
    .out_buzzer_on_o         (out_o.buzzer_on),
    .out_tone_divider_o      (out_o.tone_divider),
    .out_echo_valid_o        (out_o.echo_valid),
    .out_echo_byte_o         (out_o.echo_byte),
    .out_event_res_o         (out_o.event_res),
    .out_reported_limit_o    (out_o.reported_limit),
    .out_seconds_remaining_o (out_o.seconds_remaining)
  );

endmodule

// ----- tb/sv/tb_serial_pinged_watchdog.sv -----
// Self-checking testbench for serial_pinged_watchdog: a queue-fed driver, a monitor
// and an in-bench watchdog predictor compare every status transfer field by field.
// Depends on spw_pkg, spw_in_if, spw_out_if and the serial_pinged_watchdog RTL.
module tb_serial_pinged_watchdog;
  timeunit 1ns;
  timeprecision 1ps;
  import spw_pkg::*;

  localparam int unsigned LINE_DEPTH = 64;
  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned SETTLE_CYCLES = 2 * LINE_DEPTH + 40;
  localparam int unsigned CALM_LO = 400;
  localparam int unsigned CALM_HI = 750;
  localparam int unsigned HOLD_AT = 1100;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned REPORT_CAP = 200;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [15:0] SAT_LIMIT = 16'hFFFF;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx;
  } wd_item_t;

  typedef struct packed {
    logic        pulse_led;
    logic        alert_led;
    logic        relay_on;
    logic        buzzer_on;
    logic [7:0]  tone_divider;
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic [2:0]  event_res;
    logic [15:0] reported_limit;
    logic [15:0] seconds_remaining;
  } wd_status_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;

  spw_in_if  in_ch ();
  spw_out_if out_ch ();

  serial_pinged_watchdog DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  wd_item_t   item_q[$];
  wd_status_t status_q[$];
  int pushed = 0;
  int accepted = 0;
  int results_seen = 0;
  int errors = 0;
  int hold_left = 0;
  bit hold_done = 0;
  bit jitter = 0;
  logic calm;

  // predictor state
  logic [15:0] cfg_boot, cfg_phase;
  logic [7:0]  cfg_tone1, cfg_tone2;
  logic [15:0] wd_count, wd_limit, ph_left;
  logic        hb;
  logic [1:0]  alarm_ph;
  logic [7:0]  line_buf [LINE_DEPTH];
  int          line_len;

  assign calm = (accepted >= CALM_LO) && (accepted < CALM_HI);

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic bit word_hit(int n, logic [31:0] w, int wlen);
    logic [7:0] a, b;
    int i;
    for (i = 0; i < n; i++) begin
      a = line_buf[i];
      b = 8'h00;
      if (i < wlen) begin
        b = w[31 - 8 * i -: 8];
      end
      if (a != b) return 1'b0;
      if (a == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic logic [15:0] limit_from(int s, int e);
    int i;
    longint v;
    bit neg;
    i = s;
    v = 0;
    neg = 1'b0;
    while (i < e && (line_buf[i] == CH_SPACE || (line_buf[i] >= CH_TAB && line_buf[i] <= CH_CR)))
      i++;
    if (i < e && (line_buf[i] == CH_PLUS || line_buf[i] == CH_MINUS)) begin
      neg = (line_buf[i] == CH_MINUS);
      i++;
    end
    while (i < e && line_buf[i] >= CH_ZERO && line_buf[i] <= CH_NINE) begin
      v = v * 10 + (line_buf[i] - CH_ZERO);
      if (v > SAT_LIMIT) v = SAT_LIMIT;
      i++;
    end
    if (neg || v == 0) return 16'd1;
    return v[15:0];
  endfunction

  function automatic logic [2:0] exec_line();
    int n;
    logic [2:0] ev;
    n = line_len;
    ev = EV_NONE;
    while (n > 0 && (line_buf[n - 1] == CH_CR || line_buf[n - 1] == CH_LF))
      n--;
    if (n > 0) begin
      if (word_hit(n, WORD_PING, MATCH_SPAN)) begin
        wd_count = wd_limit;
        ev = EV_PING;
      end else if (word_hit(n, WORD_SHOW, MATCH_SPAN)) begin
        ev = EV_SHOW;
      end else if (n >= WORD_SET_LEN && word_hit(WORD_SET_LEN, WORD_SET, WORD_SET_LEN)) begin
        wd_limit = limit_from(WORD_SET_LEN, n);
        ev = EV_SET;
      end else begin
        ev = EV_WRONG;
      end
    end
    line_len = 0;
    return ev;
  endfunction

  function automatic wd_status_t watchdog_step(logic [1:0] cmd, logic [7:0] rx);
    wd_status_t r;
    logic on;
    r = '0;
    case (cmd)
      CMD_SEC: begin
        if (alarm_ph == PH_IDLE) begin
          hb = ~hb;
          wd_count = wd_count - 16'd1;
          if (wd_count == 16'd0) begin
            alarm_ph = PH_FIRST;
            ph_left = cfg_phase;
          end
        end
      end
      CMD_BYTE: begin
        if (alarm_ph == PH_IDLE) begin
          r.echo_valid = 1'b1;
          r.echo_byte = rx;
          if (line_len < LINE_DEPTH) begin
            line_buf[line_len] = rx;
            line_len++;
          end
          if (rx == CH_CR) r.event_res = exec_line();
        end
      end
      CMD_MS: begin
        if (alarm_ph != PH_IDLE) begin
          if (ph_left <= 16'd1) begin
            if (alarm_ph == PH_FIRST) begin
              alarm_ph = PH_SECOND;
              ph_left = cfg_phase;
            end else begin
              alarm_ph = PH_IDLE;
              ph_left = 16'd0;
              wd_count = cfg_boot;
            end
          end else begin
            ph_left = ph_left - 16'd1;
          end
        end
      end
      default: ;
    endcase
    on = (alarm_ph != PH_IDLE);
    r.pulse_led = hb;
    r.alert_led = on;
    r.relay_on = on;
    r.buzzer_on = on;
    r.tone_divider = (alarm_ph == PH_FIRST) ? cfg_tone1 :
                     (alarm_ph == PH_SECOND) ? cfg_tone2 : 8'h00;
    r.reported_limit = wd_limit;
    r.seconds_remaining = wd_count;
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        status_q.push_back(watchdog_step(in_ch.cmd, in_ch.rx_byte));
        accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (item_q.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
          in_ch.valid <= 1'b1;
          in_ch.cmd <= item_q[0].cmd;
          in_ch.rx_byte <= item_q[0].rx;
          void'(item_q.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    wd_status_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: status transfer with nothing expected, actual limit %0h count %0h",
                   $time, out_ch.reported_limit, out_ch.seconds_remaining);
      end else begin
        want = status_q.pop_front();
        check_field("pulse_led", 16'(want.pulse_led), 16'(out_ch.pulse_led));
        check_field("alert_led", 16'(want.alert_led), 16'(out_ch.alert_led));
        check_field("relay_on", 16'(want.relay_on), 16'(out_ch.relay_on));
        check_field("buzzer_on", 16'(want.buzzer_on), 16'(out_ch.buzzer_on));
        check_field("tone_divider", 16'(want.tone_divider), 16'(out_ch.tone_divider));
        check_field("echo_valid", 16'(want.echo_valid), 16'(out_ch.echo_valid));
        check_field("echo_byte", 16'(want.echo_byte), 16'(out_ch.echo_byte));
        check_field("event_res", 16'(want.event_res), 16'(out_ch.event_res));
        check_field("reported_limit", want.reported_limit, out_ch.reported_limit);
        check_field("seconds_remaining", want.seconds_remaining, out_ch.seconds_remaining);
      end
      results_seen++;
    end
  end

  task automatic push_item(logic [1:0] cmd, logic [7:0] rx);
    item_q.push_back('{cmd: cmd, rx: rx});
    pushed++;
  endtask

  task automatic push_rx(logic [7:0] b);
    if (jitter && $urandom_range(0, 99) < 4) push_item(CMD_SEC, 8'($urandom));
    push_item(CMD_BYTE, b);
  endtask

  task automatic push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) push_rx(s[i]);
  endtask

  task automatic push_line(string s);
    push_text(s);
    push_rx(CH_CR);
  endtask

  task automatic push_prefix(string w);
    int i, n;
    n = $urandom_range(1, w.len());
    for (i = 0; i < n; i++) push_rx(w[i]);
  endtask

  task automatic push_junk_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == CH_CR) b = CH_LF;
    push_rx(b);
  endtask

  task automatic push_line_end();
    int k;
    k = $urandom_range(0, 99);
    if (k < 15) push_rx(CH_LF);
    else if (k < 20) repeat ($urandom_range(2, 4)) push_rx(CH_LF);
    push_rx(CH_CR);
  endtask

  task automatic push_set_line();
    int k;
    push_text("set");
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 2) == 0) push_rx(CH_TAB + 8'($urandom_range(0, 3)));
      else push_rx(CH_SPACE);
    end
    k = $urandom_range(0, 9);
    if (k == 0) push_rx(CH_MINUS);
    else if (k == 1) push_rx(CH_PLUS);
    k = $urandom_range(0, 99);
    if (k < 80) push_text($sformatf("%0d", $urandom_range(0, 20)));
    else if (k < 93) repeat ($urandom_range(0, 5)) push_rx(CH_ZERO + 8'($urandom_range(0, 9)));
    else repeat ($urandom_range(6, 12)) push_rx(CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 9) == 0) push_junk_byte();
    push_line_end();
  endtask

  task automatic push_command_line();
    int k;
    k = $urandom_range(0, 99);
    if (k < 35) begin
      push_prefix("ping");
      push_line_end();
    end else if (k < 55) begin
      push_prefix("show");
      push_line_end();
    end else begin
      push_set_line();
    end
  endtask

  task automatic push_noise_line();
    int k;
    k = $urandom_range(0, 99);
    if (k < 20) begin
      push_prefix(($urandom_range(0, 1) == 1) ? "ping" : "show");
      push_rx(8'h00);
    end else if (k < 30) begin
      push_prefix("set");
    end
    repeat ($urandom_range(0, 10)) push_rx(8'($urandom));
    push_rx(CH_CR);
  endtask

  task automatic push_long_line();
    if ($urandom_range(0, 1) == 1) begin
      push_text("set ");
      repeat ($urandom_range(LINE_DEPTH - 8, LINE_DEPTH + 12))
        push_rx(CH_ZERO + 8'($urandom_range(0, 9)));
    end else begin
      push_prefix("ping");
      repeat ($urandom_range(LINE_DEPTH - 8, LINE_DEPTH + 12)) push_junk_byte();
    end
    push_line_end();
  endtask

  task automatic push_chunk();
    int k;
    k = $urandom_range(0, 99);
    if (k < 28) repeat ($urandom_range(1, 3)) push_item(CMD_SEC, 8'($urandom));
    else if (k < 50) repeat ($urandom_range(1, 8)) push_item(CMD_MS, 8'($urandom));
    else if (k < 82) push_command_line();
    else if (k < 94) push_noise_line();
    else if (k < 97) push_long_line();
    else push_item(CMD_NONE, 8'($urandom));
  endtask

  task automatic drain();
    while (accepted != pushed || status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      CFG_BOOT:  cfg_boot = data;
      CFG_PHASE: cfg_phase = data;
      CFG_TONE1: cfg_tone1 = data[7:0];
      CFG_TONE2: cfg_tone2 = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] boot, logic [15:0] phase, logic [15:0] t1,
                          logic [15:0] t2);
    write_reg(CFG_BOOT, boot);
    write_reg(CFG_PHASE, phase);
    write_reg(CFG_TONE1, t1);
    write_reg(CFG_TONE2, t2);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic leave_alarm();
    int ticks;
    ticks = 0;
    if (alarm_ph == PH_FIRST)
      ticks = ((ph_left > 1) ? ph_left : 1) + ((cfg_phase > 1) ? cfg_phase : 1);
    else if (alarm_ph == PH_SECOND)
      ticks = (ph_left > 1) ? ph_left : 1;
    repeat (ticks) push_item(CMD_MS, 8'($urandom));
    drain();
  endtask

  task automatic run_phase(logic [15:0] boot, logic [15:0] phase, logic [15:0] t1,
                           logic [15:0] t2, int n_items);
    int target;
    leave_alarm();
    set_regs(boot, phase, t1, t2);
    push_line("set 4");
    push_line("ping");
    jitter = 1'b1;
    target = pushed + n_items;
    while (pushed < target) push_chunk();
    jitter = 1'b0;
    drain();
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_BOOT;
    cfg_data = 16'h0000;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_SEC;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;
    cfg_boot = BOOT_RST;
    cfg_phase = PHASE_RST;
    cfg_tone1 = TONE1_RST;
    cfg_tone2 = TONE2_RST;
    wd_count = 16'(COUNT_RST);
    wd_limit = 16'(COUNT_RST);
    ph_left = 16'd0;
    hb = 1'b0;
    alarm_ph = PH_IDLE;
    line_len = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tone writes with upper data bits set, a CMD_NONE item, short, wrong and negative set lines
    set_regs(16'd3, 16'd2, 16'hFFFF, 16'hA500);
    push_item(CMD_NONE, 8'hFF);
    push_item(CMD_MS, 8'h00);
    push_rx(CH_CR);
    push_line("p");
    push_line("sh");
    push_line("x");
    push_line("set-5");
    push_line("p");
    push_item(CMD_SEC, 8'h00);
    push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_SEC, 8'h55);
    repeat (4) push_item(CMD_MS, 8'hAA);
    drain();

    run_phase(16'd1, 16'd0, 16'hC300, 16'h00FF, 280);
    run_phase(16'd0, 16'd1, 16'($urandom), 16'($urandom), 280);
    run_phase(16'hFFFF, 16'd3, 16'($urandom), 16'($urandom), 280);
    run_phase(16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)), 16'($urandom),
              16'($urandom), 280);
    run_phase(16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)), 16'($urandom),
              16'($urandom), 280);
    run_phase(16'($urandom_range(1, 12)), 16'hFFFF, 16'($urandom), 16'($urandom), 200);

    if (errors == 0 && status_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(25_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/spw_pkg.sv
hdl/spw_in_if.sv
hdl/spw_out_if.sv
hdl/spw_ctrl.sv
hdl/spw_dp.sv
hdl/serial_pinged_watchdog.sv
tb/sv/tb_serial_pinged_watchdog.sv
